// ----- rtl/ccss_pkg.sv -----
// ----------------------------------------------------------------------------
// ccss_pkg
// Shared types, constants and tables of the seven-segment countdown unit.
// ----------------------------------------------------------------------------
package ccss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned SECS_W     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_YEAR   = 3'd0,
    CFG_TARGET_MONTH  = 3'd1,
    CFG_TARGET_DAY    = 3'd2,
    CFG_TARGET_HOUR   = 3'd3,
    CFG_TARGET_MINUTE = 3'd4
  } cfg_idx_e;

  localparam logic [11:0] TARGET_YEAR_RST   = 12'd2026;
  localparam logic [3:0]  TARGET_MONTH_RST  = 4'd10;
  localparam logic [4:0]  TARGET_DAY_RST    = 5'd10;
  localparam logic [4:0]  TARGET_HOUR_RST   = 5'd12;
  localparam logic [5:0]  TARGET_MINUTE_RST = 6'd0;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } req_t;

  typedef struct packed {
    logic [7:0] seg_leftmost;
    logic [7:0] seg_second;
    logic [7:0] seg_third;
    logic [7:0] seg_rightmost;
    logic       arrived;
    logic       minutes_shown;
  } res_t;

  // Binary calendar instant, wide enough for both clock and target
  typedef struct packed {
    logic [11:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } cal_t;

  localparam logic signed [SECS_W-1:0] SECS_PER_DAY  = 40'sd86400;
  localparam logic signed [SECS_W-1:0] SAT_SECS      = 40'sd36000000;
  localparam logic signed [SECS_W-1:0] MIN_VIEW_SECS = 40'sd360000;
  localparam logic [13:0]              HOURS_CAP     = 14'd9999;

  // Reciprocals: x/100 = (x*5243)>>19, x/225 ~ (x*DIV225)>>32, x/15 ~ (x*DIV15)>>24
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam logic [24:0] DIV225_MUL = 25'd19088743;
  localparam logic [20:0] DIV15_MUL  = 21'd1118481;

  localparam logic [7:0] DP_BIT = 8'h80;

  localparam logic [7:0] FONT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Days before the first of the month in a March-based year, by month value
  localparam logic [9:0] MONTH_OFFSET [32] = '{
    10'd275, 10'd306, 10'd337, 10'd0,   10'd31,  10'd61,  10'd92,  10'd122,
    10'd153, 10'd184, 10'd214, 10'd245, 10'd275, 10'd306, 10'd337, 10'd367,
    10'd398, 10'd428, 10'd459, 10'd490, 10'd520, 10'd551, 10'd581, 10'd612,
    10'd643, 10'd673, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0
  };

  typedef logic [7:0] bcd_tab_t [100];

  function automatic bcd_tab_t build_bcd_tab();
    bcd_tab_t   tab;
    logic [3:0] tens;
    logic [3:0] units;
    tens  = '0;
    units = '0;
    for (int i = 0; i < 100; i++) begin
      tab[i] = {tens, units};
      if (units == 4'd9) begin
        units = '0;
        tens  = tens + 4'd1;
      end else begin
        units = units + 4'd1;
      end
    end
    return tab;
  endfunction

  // Two-digit BCD of 0..99
  localparam bcd_tab_t BCD100 = build_bcd_tab();

endpackage

// ----- rtl/ccss_req_if.sv -----
// ----------------------------------------------------------------------------
// ccss_req_if
// Request channel: one BCD clock reading per request.
// ----------------------------------------------------------------------------
interface ccss_req_if;
  logic           valid;
  logic           ready;
  ccss_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ccss_res_if.sv -----
// ----------------------------------------------------------------------------
// ccss_res_if
// Result channel: four segment codes and status flags.
// ----------------------------------------------------------------------------
interface ccss_res_if;
  logic           valid;
  logic           ready;
  ccss_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ccss_secs.sv -----
// ----------------------------------------------------------------------------
// ccss_secs
// Four-stage conversion of a calendar instant into a seconds count on a
// proleptic Gregorian day count (constant epoch offset left out).
// ----------------------------------------------------------------------------
module ccss_secs (
  input  logic                                clk_i,
  input  logic [3:0]                          en_i,
  input  ccss_pkg::cal_t                      cal_i,
  output logic signed [ccss_pkg::SECS_W-1:0]  secs_o
);

  logic signed [12:0] y_d, y_q;
  logic [10:0]        dd_d, dd_a_q, dd_b_q;
  logic [17:0]        tod_d, tod_a_q, tod_b_q, tod_c_q;
  logic [11:0]        yn;
  logic [24:0]        p100;
  logic [5:0]         q100_q;
  logic [9:0]         y4_q;
  logic signed [21:0] y365_d, y365_q;
  logic signed [21:0] f_d, f_q;
  logic signed [ccss_pkg::SECS_W-1:0] secs_d, secs_q;

  // stage a: year shift, month offset, time of day
  always_comb begin
    y_d   = $signed({1'b0, cal_i.year}) - ((cal_i.month <= 5'd2) ? 13'sd1 : 13'sd0);
    dd_d  = 11'(ccss_pkg::MONTH_OFFSET[cal_i.month]) + 11'(cal_i.day);
    tod_d = 18'(cal_i.hour) * 18'd3600 + 18'(cal_i.minute) * 18'd60 + 18'(cal_i.second);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y_q     <= y_d;
      dd_a_q  <= dd_d;
      tod_a_q <= tod_d;
    end
  end

  // stage b: leap terms; year -1 contributes none
  always_comb begin
    yn     = y_q[12] ? 12'd0 : y_q[11:0];
    p100   = 25'(yn) * 25'(ccss_pkg::DIV100_MUL);
    y365_d = $signed({{9{y_q[12]}}, y_q}) * 22'sd365;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q100_q  <= p100[24:19];
      y4_q    <= yn[11:2];
      y365_q  <= y365_d;
      dd_b_q  <= dd_a_q;
      tod_b_q <= tod_a_q;
    end
  end

  // stage c: day count
  assign f_d = y365_q + $signed({12'b0, y4_q}) - $signed({16'b0, q100_q})
             + $signed({18'b0, q100_q[5:2]}) + $signed({11'b0, dd_b_q});

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      f_q     <= f_d;
      tod_c_q <= tod_b_q;
    end
  end

  // stage d: seconds
  assign secs_d = $signed({{18{f_q[21]}}, f_q}) * ccss_pkg::SECS_PER_DAY
                + $signed({22'b0, tod_c_q});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      secs_q <= secs_d;
    end
  end

  assign secs_o = secs_q;

endmodule

// ----- rtl/calendar_countdown_seven_segment_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_countdown_seven_segment_unit
// Countdown from a BCD clock reading to a configured target, shown as four
// seven-segment codes (hours, or minutes under 100 hours).
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// req_i    in   valid / ready      ccss_pkg::req_t, BCD clock reading
// res_o    out  valid / ready      ccss_pkg::res_t, segment codes and flags
// cfg      in   cfg_we_i only      cfg_idx_i, cfg_data_i (target time)
//
// One request per clock while res_o is not stalled; a request reaches the
// result through eleven register stages (BCD decode, four-stage seconds count, subtract,
// reciprocal divide, divide correction, two digit split stages, encode).
// Reset clears all stage valid bits and loads the default target.
// A stall at res_o holds the last stage; each stage loads while it is empty
// or its successor moves, so bubbles still fill and nothing repeats.
// ----------------------------------------------------------------------------
module calendar_countdown_seven_segment_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ccss_req_if.sink                           req_i,
  ccss_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [ccss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ccss_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned NSTG = 11;

  logic [NSTG-1:0] vld_q, en, vld_in;

  logic [11:0] tgt_year_q;
  logic [3:0]  tgt_month_q;
  logic [4:0]  tgt_day_q;
  logic [4:0]  tgt_hour_q;
  logic [5:0]  tgt_minute_q;

  ccss_pkg::cal_t s0_d, s0_q, tgt_cal;
  logic signed [ccss_pkg::SECS_W-1:0] now_secs, tgt_secs, rem_q;

  logic        arr6_d, sat6_d, mm6_d;
  logic        arr6_q, sat6_q, mm6_q;
  logic [46:0] ph;
  logic [37:0] pm;
  logic [21:0] hx_q;
  logic [16:0] mx_q;
  logic [14:0] q0h_q;
  logic [13:0] q0m_q;

  logic [22:0] rh;
  logic [17:0] rm;
  logic [14:0] qh;
  logic [13:0] qm;
  logic [13:0] v7_d, v7_q;
  logic        arr7_q, mm7_q;

  logic [26:0] p8;
  logic [6:0]  q1_q;
  logic [13:0] v8_q;
  logic        arr8_q, mm8_q;

  logic [6:0]       lo9;
  logic [7:0]       hi_bcd, lo_bcd;
  logic [3:0][3:0]  dig_q;
  logic             arr9_q, mm9_q;

  logic           b3, b2, b1;
  ccss_pkg::res_t res_d, res_q;

  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    logic [7:0] r;
    r = {1'b0, v[7:4], 3'b0} + {3'b0, v[7:4], 1'b0} + {4'b0, v[3:0]};
    return r;
  endfunction

  // stage enables: load when empty or when the next stage moves
  assign en[NSTG-1] = ~vld_q[NSTG-1] | res_o.ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign vld_in      = {vld_q[NSTG-2:0], req_i.valid};
  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // target registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_year_q   <= ccss_pkg::TARGET_YEAR_RST;
      tgt_month_q  <= ccss_pkg::TARGET_MONTH_RST;
      tgt_day_q    <= ccss_pkg::TARGET_DAY_RST;
      tgt_hour_q   <= ccss_pkg::TARGET_HOUR_RST;
      tgt_minute_q <= ccss_pkg::TARGET_MINUTE_RST;
    end else if (cfg_we_i) begin
      case (ccss_pkg::cfg_idx_e'(cfg_idx_i))
        ccss_pkg::CFG_TARGET_YEAR:   tgt_year_q   <= cfg_data_i;
        ccss_pkg::CFG_TARGET_MONTH:  tgt_month_q  <= cfg_data_i[3:0];
        ccss_pkg::CFG_TARGET_DAY:    tgt_day_q    <= cfg_data_i[4:0];
        ccss_pkg::CFG_TARGET_HOUR:   tgt_hour_q   <= cfg_data_i[4:0];
        ccss_pkg::CFG_TARGET_MINUTE: tgt_minute_q <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // stage 0: BCD decode
  always_comb begin
    s0_d.year   = 12'd2000 + {4'b0, bcd_dec(req_i.data.year_bcd)};
    s0_d.month  = 5'(bcd_dec({3'b0, req_i.data.month_bcd}));
    s0_d.day    = 6'(bcd_dec({2'b0, req_i.data.day_bcd}));
    s0_d.hour   = 6'(bcd_dec({2'b0, req_i.data.hour_bcd}));
    s0_d.minute = 7'(bcd_dec({1'b0, req_i.data.minute_bcd}));
    s0_d.second = 7'(bcd_dec({1'b0, req_i.data.second_bcd}));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= s0_d;
    end
  end

  always_comb begin
    tgt_cal.year   = tgt_year_q;
    tgt_cal.month  = {1'b0, tgt_month_q};
    tgt_cal.day    = {1'b0, tgt_day_q};
    tgt_cal.hour   = {1'b0, tgt_hour_q};
    tgt_cal.minute = {1'b0, tgt_minute_q};
    tgt_cal.second = '0;
  end

  // stages 1..4
  ccss_secs u_now_secs (
    .clk_i  (clk_i),
    .en_i   (en[4:1]),
    .cal_i  (s0_q),
    .secs_o (now_secs)
  );

  ccss_secs u_tgt_secs (
    .clk_i  (clk_i),
    .en_i   (en[4:1]),
    .cal_i  (tgt_cal),
    .secs_o (tgt_secs)
  );

  // stage 5: remainder
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rem_q <= tgt_secs - now_secs;
    end
  end

  // stage 6: mode flags and reciprocal products
  always_comb begin
    arr6_d = rem_q[ccss_pkg::SECS_W-1] || (rem_q == '0);
    sat6_d = !rem_q[ccss_pkg::SECS_W-1] && (rem_q >= ccss_pkg::SAT_SECS);
    mm6_d  = !arr6_d && (rem_q < ccss_pkg::MIN_VIEW_SECS);
    ph     = 47'(rem_q[25:4]) * 47'(ccss_pkg::DIV225_MUL);
    pm     = 38'(rem_q[18:2]) * 38'(ccss_pkg::DIV15_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      arr6_q <= arr6_d;
      sat6_q <= sat6_d;
      mm6_q  <= mm6_d;
      hx_q   <= rem_q[25:4];
      mx_q   <= rem_q[18:2];
      q0h_q  <= ph[46:32];
      q0m_q  <= pm[37:24];
    end
  end

  // stage 7: quotient correction, value select
  always_comb begin
    rh = {1'b0, hx_q} - 23'(q0h_q) * 23'd225;
    rm = {1'b0, mx_q} - 18'(q0m_q) * 18'd15;
    qh = (rh >= 23'd225) ? q0h_q + 15'd1 : q0h_q;
    qm = (rm >= 18'd15) ? q0m_q + 14'd1 : q0m_q;
    if (arr6_q) begin
      v7_d = '0;
    end else if (mm6_q) begin
      v7_d = qm;
    end else if (sat6_q) begin
      v7_d = ccss_pkg::HOURS_CAP;
    end else begin
      v7_d = qh[13:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      v7_q   <= v7_d;
      arr7_q <= arr6_q;
      mm7_q  <= mm6_q;
    end
  end

  // stage 8: upper two digits
  assign p8 = 27'(v7_q) * 27'(ccss_pkg::DIV100_MUL);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      q1_q   <= p8[25:19];
      v8_q   <= v7_q;
      arr8_q <= arr7_q;
      mm8_q  <= mm7_q;
    end
  end

  // stage 9: digit split
  always_comb begin
    lo9    = 7'(v8_q - 14'(q1_q) * 14'd100);
    hi_bcd = ccss_pkg::BCD100[q1_q];
    lo_bcd = ccss_pkg::BCD100[lo9];
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      dig_q  <= {hi_bcd, lo_bcd};
      arr9_q <= arr8_q;
      mm9_q  <= mm8_q;
    end
  end

  // stage 10: segment encode, leading-zero blanking
  always_comb begin
    b3 = (dig_q[3] == 4'd0);
    b2 = b3 && (dig_q[2] == 4'd0);
    b1 = b2 && (dig_q[1] == 4'd0);
    res_d.arrived       = arr9_q;
    res_d.minutes_shown = mm9_q;
    if (arr9_q) begin
      res_d.seg_leftmost  = ccss_pkg::FONT[0] | ccss_pkg::DP_BIT;
      res_d.seg_second    = ccss_pkg::FONT[0] | ccss_pkg::DP_BIT;
      res_d.seg_third     = ccss_pkg::FONT[0] | ccss_pkg::DP_BIT;
      res_d.seg_rightmost = ccss_pkg::FONT[0] | ccss_pkg::DP_BIT;
    end else begin
      res_d.seg_leftmost  = (b3 ? 8'h00 : ccss_pkg::FONT[dig_q[3]])
                          | (mm9_q ? ccss_pkg::DP_BIT : 8'h00);
      res_d.seg_second    = b2 ? 8'h00 : ccss_pkg::FONT[dig_q[2]];
      res_d.seg_third     = b1 ? 8'h00 : ccss_pkg::FONT[dig_q[1]];
      res_d.seg_rightmost = ccss_pkg::FONT[dig_q[0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = vld_q[NSTG-1];
  assign res_o.data  = res_q;

  // checks
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (&vld_q))
    else $error("request stalled while a stage is empty");

  a_hour_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && !arr6_q && !sat6_q && !mm6_q) |-> (rh < 23'd450))
    else $error("hour quotient estimate off by more than one");

  a_min_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && mm6_q) |-> (rm < 18'd30))
    else $error("minute quotient estimate off by more than one");

  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (q1_q <= 7'd99))
    else $error("upper digit pair out of range");

  a_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.minutes_shown) |->
      (!res_o.data.arrived && res_o.data.seg_leftmost[7] &&
       (res_o.data.seg_rightmost != 8'h00)))
    else $error("minutes view without its decimal point or last digit");

endmodule
